[hw/rtl/lwf_pkg.sv]
// Types and fixed constants shared by the Laplacian window filter.
`default_nettype none

package lwf_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int OUT_COL_W  = 10;
  localparam int IWIDTH_W   = 11;
  localparam int IHEIGHT_W  = 13;
  localparam int MASK_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int MAX_HEIGHT = 4096;
  localparam int PIX_MAX    = 255;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_SIZE    = 2'd2;

  localparam logic [IWIDTH_W-1:0]  RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [IHEIGHT_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [MASK_W-1:0]    RST_MASK_SIZE    = 3'd3;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]     sharp_pixel;
    logic [ROW_W-1:0]     out_row;
    logic [OUT_COL_W-1:0] out_col;
  } out_item_t;

endpackage

`default_nettype wire

[hw/rtl/laplacian_window_filter.sv]
// Streaming n-by-n Laplacian high-pass filter over a raster pixel stream.
//
// Input channel (in_valid/in_stall/in_data): one grayscale pixel per transfer
// in raster order; frame_start on a pixel restarts the row/column count.
// Output channel (out_valid/out_stall/out_data): one clamped result per fully
// covered window, tagged with the row and column of the window centre. Border
// pixels of the output image are not produced.
// Configuration (cfg_we/cfg_idx/cfg_wdata): image width, image height and
// mask size, written while the block is idle.
//
// Throughput: one pixel per clock unless in_stall is raised. The previous
// rows live in one line memory, one word per column holding all stored
// rows, read and written back once per pixel; a write-to-read bypass covers
// back-to-back pixels on the same column (width of one). The window is a
// bank of shift registers. A result is registered after each of line read,
// window shift, row sums, total and clamp before it appears on out_valid.
// Stall: while out_valid is held by out_stall and a result waits in the last
// stage, the whole pipeline freezes and in_stall is raised; empty slots still
// drain, so pixels keep being taken while a single result waits.
// Reset: counters and config return to their defaults (640 x 480, 3 x 3);
// the line memory and window are not cleared, no clearing pass is run.
`default_nettype none

module laplacian_window_filter #(
  parameter int MAX_MASK  = 7,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lwf_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lwf_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [lwf_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [lwf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import lwf_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int NW    = $clog2(MAX_MASK + 1);
  localparam int NSW   = 2 * NW;
  localparam int LINES = (MAX_MASK > 1) ? MAX_MASK - 1 : 1;
  localparam int LW    = LINES * PIX_W;
  localparam int RSW   = PIX_W + $clog2(MAX_MASK + 1);
  localparam int TW    = PIX_W + $clog2(MAX_MASK * MAX_MASK + 1);
  localparam int CXW   = (CW > OUT_COL_W) ? CW : OUT_COL_W;

  // ---------------------------------------------------------------- config
  logic [IWIDTH_W-1:0]  image_width_r;
  logic [IHEIGHT_W-1:0] image_height_r;
  logic [MASK_W-1:0]    mask_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= RST_IMAGE_WIDTH;
      image_height_r <= RST_IMAGE_HEIGHT;
      mask_size_r    <= RST_MASK_SIZE;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[IWIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[IHEIGHT_W-1:0];
        CFG_MASK_SIZE:    mask_size_r    <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes: zero reads as one, oversize saturates.
  logic [WW-1:0]        w_eff;
  logic [IHEIGHT_W-1:0] h_eff;
  logic [NW-1:0]        n_eff;

  always_comb begin
    if (image_width_r == '0) begin
      w_eff = WW'(1);
    end else if (int'(image_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width_r);
    end
    if (image_height_r == '0) begin
      h_eff = IHEIGHT_W'(1);
    end else if (int'(image_height_r) > MAX_HEIGHT) begin
      h_eff = IHEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height_r;
    end
    if (mask_size_r == '0) begin
      n_eff = NW'(1);
    end else if (int'(mask_size_r) > MAX_MASK) begin
      n_eff = NW'(MAX_MASK);
    end else begin
      n_eff = NW'(mask_size_r);
    end
  end

  // ------------------------------------------------------- flow control
  logic s4_vld_r;
  logic out_vld_r;
  logic out_free;
  logic adv;
  logic acc;

  // Pipeline moves unless a finished result is stuck behind a held output.
  assign out_free = !out_vld_r || !out_stall;
  assign adv      = out_free || !s4_vld_r;
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  // ------------------------------------------- stage 0: position counters
  logic [ROW_W-1:0]     row_count_r, row_count_nxt;
  logic [CW-1:0]        col_count_r, col_count_nxt;
  logic [ROW_W-1:0]     cur_r;
  logic [CW-1:0]        cur_c;
  logic [CW:0]          c_inc;
  logic [ROW_W:0]       r_inc;
  logic [NW-1:0]        half0;
  logic                 prod0;
  logic [ROW_W-1:0]     orow0;
  logic [CXW-1:0]       ocol_full;

  always_comb begin
    cur_r = in_data.frame_start ? '0 : row_count_r;
    cur_c = in_data.frame_start ? '0 : col_count_r;
    half0 = n_eff >> 1;

    prod0 = (int'(cur_r) + 1 >= int'(n_eff)) && (int'(cur_c) + 1 >= int'(n_eff)) &&
            (int'(cur_r) < int'(h_eff)) && (int'(cur_c) < int'(w_eff));

    // centre = position - (n-1) + n/2
    orow0     = cur_r + ROW_W'(half0) + ROW_W'(1) - ROW_W'(n_eff);
    ocol_full = CXW'(cur_c) + CXW'(half0) + CXW'(1) - CXW'(n_eff);

    c_inc = (CW+1)'(cur_c) + (CW+1)'(1);
    r_inc = (ROW_W+1)'(cur_r) + (ROW_W+1)'(1);
    if (int'(c_inc) >= int'(w_eff)) begin
      col_count_nxt = '0;
      row_count_nxt = (int'(r_inc) >= int'(h_eff)) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      col_count_nxt = c_inc[CW-1:0];
      row_count_nxt = (int'(cur_r) >= int'(h_eff)) ? '0 : cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= '0;
      col_count_r <= '0;
    end else if (acc) begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
    end
  end

  // Stage 1 registers
  logic                 s1_vld_r;
  logic [PIX_W-1:0]     s1_px_r;
  logic [CW-1:0]        s1_c_r;
  logic                 s1_prod_r;
  logic [ROW_W-1:0]     s1_orow_r;
  logic [OUT_COL_W-1:0] s1_ocol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px_r   <= in_data.pixel;
      s1_c_r    <= cur_c;
      s1_prod_r <= prod0;
      s1_orow_r <= orow0;
      s1_ocol_r <= ocol_full[OUT_COL_W-1:0];
    end
  end

  // -------------------------------------------------------- line memory
  // One word per column: byte k holds the pixel k+1 rows above.
  logic [LW-1:0] line_mem [MAX_WIDTH];
  logic [LW-1:0] rd_data_r;
  logic [LW-1:0] line_word;
  logic [LW-1:0] wr_word;
  logic          mem_we;

  logic          fwd_vld_r;
  logic [CW-1:0] fwd_addr_r;
  logic [LW-1:0] fwd_data_r;

  assign mem_we = adv && s1_vld_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[s1_c_r] <= wr_word;
    end
    if (adv) begin
      rd_data_r <= line_mem[cur_c];
    end
  end

  // Bypass: the write issued on the edge of our read is not in rd_data_r.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else if (adv) begin
      fwd_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_addr_r <= s1_c_r;
      fwd_data_r <= wr_word;
    end
  end

  // ------------------------------------------ stage 1: window shift
  logic [PIX_W-1:0] newcol  [MAX_MASK];
  logic [PIX_W-1:0] win_r   [MAX_MASK][MAX_MASK];
  logic [PIX_W-1:0] win_nxt [MAX_MASK][MAX_MASK];

  always_comb begin
    line_word = (fwd_vld_r && (fwd_addr_r == s1_c_r)) ? fwd_data_r : rd_data_r;

    wr_word = line_word;
    wr_word[PIX_W-1:0] = s1_px_r;
    for (int k = 1; k < LINES; k++) begin
      wr_word[k*PIX_W +: PIX_W] = line_word[(k-1)*PIX_W +: PIX_W];
    end

    for (int i = 0; i < MAX_MASK; i++) begin
      newcol[i] = '0;
      if (i + 1 == int'(n_eff)) begin
        newcol[i] = s1_px_r;
      end else begin
        for (int k = 0; k < LINES; k++) begin
          if (k + 2 + i == int'(n_eff)) begin
            newcol[i] = line_word[k*PIX_W +: PIX_W];
          end
        end
      end
    end

    // Active columns shift left by one; the new column enters at n-1.
    for (int i = 0; i < MAX_MASK; i++) begin
      for (int j = 0; j < MAX_MASK; j++) begin
        win_nxt[i][j] = win_r[i][j];
        if (i < int'(n_eff) && j + 1 == int'(n_eff)) begin
          win_nxt[i][j] = newcol[i];
        end
      end
      for (int j = 0; j < MAX_MASK - 1; j++) begin
        if (i < int'(n_eff) && j + 1 < int'(n_eff)) begin
          win_nxt[i][j] = win_r[i][j+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_r <= win_nxt;
    end
  end

  logic                 s2_vld_r;
  logic [ROW_W-1:0]     s2_orow_r;
  logic [OUT_COL_W-1:0] s2_ocol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r && s1_prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_orow_r <= s1_orow_r;
      s2_ocol_r <= s1_ocol_r;
    end
  end

  // ------------------------------------------ stage 2: row sums, centre
  logic [RSW-1:0]   rowsum [MAX_MASK];
  logic [PIX_W-1:0] center;

  always_comb begin
    center = '0;
    for (int i = 0; i < MAX_MASK; i++) begin
      rowsum[i] = '0;
      for (int j = 0; j < MAX_MASK; j++) begin
        if (i < int'(n_eff) && j < int'(n_eff)) begin
          rowsum[i] = rowsum[i] + RSW'(win_r[i][j]);
        end
      end
      if (i == int'(n_eff >> 1)) begin
        center = win_r[i][i];
      end
    end
  end

  logic                 s3_vld_r;
  logic [RSW-1:0]       s3_rowsum_r [MAX_MASK];
  logic [PIX_W-1:0]     s3_center_r;
  logic [ROW_W-1:0]     s3_orow_r;
  logic [OUT_COL_W-1:0] s3_ocol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_rowsum_r <= rowsum;
      s3_center_r <= center;
      s3_orow_r   <= s2_orow_r;
      s3_ocol_r   <= s2_ocol_r;
    end
  end

  // ------------------------------ stage 3: total and centre weight
  // centre*(n*n-1) - others == centre*n*n - total
  logic [TW-1:0]  total;
  logic [NSW-1:0] nsq;
  logic [TW-1:0]  cterm;

  always_comb begin
    total = '0;
    for (int i = 0; i < MAX_MASK; i++) begin
      total = total + TW'(s3_rowsum_r[i]);
    end
    nsq   = NSW'(n_eff) * NSW'(n_eff);
    cterm = TW'(s3_center_r) * TW'(nsq);
  end

  logic [TW-1:0]        s4_total_r;
  logic [TW-1:0]        s4_cterm_r;
  logic [ROW_W-1:0]     s4_orow_r;
  logic [OUT_COL_W-1:0] s4_ocol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_total_r <= total;
      s4_cterm_r <= cterm;
      s4_orow_r  <= s3_orow_r;
      s4_ocol_r  <= s3_ocol_r;
    end
  end

  // ---------------------------------- stage 4: difference and clamp
  logic [TW:0]      diff;
  logic [PIX_W-1:0] sharp;

  always_comb begin
    diff = {1'b0, s4_cterm_r} - {1'b0, s4_total_r};
    if (diff[TW]) begin
      sharp = '0;
    end else if (diff[TW-1:0] > TW'(PIX_MAX)) begin
      sharp = PIX_W'(PIX_MAX);
    end else begin
      sharp = diff[PIX_W-1:0];
    end
  end

  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r.sharp_pixel <= sharp;
      out_data_r.out_row     <= s4_orow_r;
      out_data_r.out_col     <= s4_ocol_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // ------------------------------------------------------- assertions
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s4_vld_r) && $stable(s4_total_r) && $stable(s1_vld_r))
    else $error("pipeline moved while the last stage was blocked");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(s4_vld_r))
    else $error("result appeared without a finished last stage");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !in_data.frame_start) |=>
      (col_count_r != $past(col_count_r)) || ($past(w_eff) == WW'(1)))
    else $error("column counter failed to move on a pixel transfer");

endmodule

`default_nettype wire

[test/tb_laplacian_window_filter.sv]
// Self-checking testbench for the streaming Laplacian window filter.
`timescale 1ns / 100ps

module tb_laplacian_window_filter;
  import lwf_pkg::*;

  localparam int MAX_MASK      = 7;
  localparam int MAX_WIDTH     = 1024;
  localparam int PIPE_DRAIN    = 8;        // drain margin over the block's pipeline depth
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_PIXELS = 500;

  // Image texture for one row of stimulus
  typedef enum int {TEX_NOISE, TEX_SMOOTH, TEX_BINARY} texture_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow copy of the filter: line stores, window, counters and registers
  logic [PIX_W-1:0]     line_mem [MAX_MASK-1][MAX_WIDTH];
  logic [PIX_W-1:0]     win_pix  [MAX_MASK][MAX_MASK];
  int                   row_pos;
  int                   col_pos;
  logic [IWIDTH_W-1:0]  reg_width;
  logic [IHEIGHT_W-1:0] reg_height;
  logic [MASK_W-1:0]    reg_mask;

  out_item_t   sharp_q[$];       // filter results still to come out, oldest first
  out_item_t   want;
  bit          no_idle         = 1'b0;
  int unsigned stall_left      = 0;
  int unsigned cycle_count     = 0;
  int unsigned error_count     = 0;
  int unsigned pixels_sent     = 0;
  int unsigned results_checked = 0;
  int unsigned phases_run      = 0;

  always #5 clk = ~clk;

  laplacian_window_filter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: check each transfer against the oldest prediction, then
  // draw how long the next result is held off.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (sharp_q.size() == 0) begin
        $error("unexpected result: sharp_pixel %0d out_row %0d out_col %0d",
               out_data.sharp_pixel, out_data.out_row, out_data.out_col);
        error_count++;
      end else begin
        want = sharp_q.pop_front();
        if (out_data.sharp_pixel !== want.sharp_pixel) begin
          $error("sharp_pixel: expected %0d, actual %0d", want.sharp_pixel,
                 out_data.sharp_pixel);
          error_count++;
        end
        if (out_data.out_row !== want.out_row) begin
          $error("out_row: expected %0d, actual %0d", want.out_row, out_data.out_row);
          error_count++;
        end
        if (out_data.out_col !== want.out_col) begin
          $error("out_col: expected %0d, actual %0d", want.out_col, out_data.out_col);
          error_count++;
        end
      end
      stall_left = no_idle ? 0 : $urandom_range(0, 4);
    end else if (out_valid && out_stall && stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  task automatic reset_predictor();
    int k;
    int c;
    reg_width  = RST_IMAGE_WIDTH;
    reg_height = RST_IMAGE_HEIGHT;
    reg_mask   = RST_MASK_SIZE;
    for (k = 0; k < MAX_MASK - 1; k++)
      for (c = 0; c < MAX_WIDTH; c++) line_mem[k][c] = '0;
    for (k = 0; k < MAX_MASK; k++)
      for (c = 0; c < MAX_MASK; c++) win_pix[k][c] = '0;
    row_pos = 0;
    col_pos = 0;
  endtask

  // Advance the shadow filter by one pixel; queue a result when the pixel
  // completes a fully covered window inside the image.
  task automatic predict_pixel(input in_item_t item);
    int w, h, n, r, c, half, i, j, k;
    int centre, others, diff;
    logic [PIX_W-1:0] new_col [MAX_MASK];
    out_item_t res;
    // out-of-range register values saturate
    w = (reg_width == 0) ? 1 : ((reg_width > MAX_WIDTH) ? MAX_WIDTH : int'(reg_width));
    h = (reg_height == 0) ? 1 :
        ((reg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(reg_height));
    n = (reg_mask == 0) ? 1 : ((reg_mask > MAX_MASK) ? MAX_MASK : int'(reg_mask));
    if (item.frame_start) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    if (c >= MAX_WIDTH) c = 0;
    // new right-hand window column: rows r-n+1 .. r at column c
    for (i = 0; i + 1 < n; i++) new_col[i] = line_mem[n-2-i][c];
    new_col[n-1] = item.pixel;
    for (i = 0; i < n; i++) begin
      for (j = 0; j + 1 < n; j++) win_pix[i][j] = win_pix[i][j+1];
      win_pix[i][n-1] = new_col[i];
    end
    // every line stage ages at this column, whatever the mask size
    for (k = MAX_MASK - 1; k > 1; k--) line_mem[k-1][c] = line_mem[k-2][c];
    line_mem[0][c] = item.pixel;
    if (r + 1 >= n && c + 1 >= n && r < h && c < w) begin
      half   = n / 2;
      centre = int'(win_pix[half][half]) * (n * n - 1);
      others = 0;
      for (i = 0; i < n; i++)
        for (j = 0; j < n; j++)
          if (i != half || j != half) others += int'(win_pix[i][j]);
      diff = centre - others;
      if (diff < 0) diff = 0;
      else if (diff > PIX_MAX) diff = PIX_MAX;
      res.sharp_pixel = PIX_W'(diff);
      res.out_row     = ROW_W'(r + 1 - n + half);
      res.out_col     = OUT_COL_W'(c + 1 - n + half);
      sharp_q.push_back(res);
    end
    // counters at or beyond the image size wrap here too
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end else if (r >= h) begin
      r = 0;
    end
    row_pos = r;
    col_pos = c;
  endtask

  // One pixel transfer, after a random gap unless idling is off
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic start);
    int gap;
    in_item_t item;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    item.pixel       = px;
    item.frame_start = start;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pixel(item);
    pixels_sent++;
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(input texture_t tex, input int base);
    int v;
    case (tex)
      TEX_NOISE:  v = $urandom_range(0, 255);
      TEX_BINARY: v = ($urandom_range(0, 1) != 0) ? 255 : 0;
      default:    v = base + int'($urandom_range(0, 6)) - 3;
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[PIX_W-1:0];
  endfunction

  // A run of pixels in raster order; texture changes with each row.
  // start_at: index of the pixel that carries frame_start, -1 for none.
  task automatic send_run(input int count, input int row_len, input int start_at);
    int p;
    int base;
    texture_t tex;
    tex  = TEX_SMOOTH;
    base = 128;
    for (p = 0; p < count; p++) begin
      if (p % row_len == 0) begin
        tex  = texture_t'($urandom_range(0, 2));
        base = $urandom_range(0, 255);
      end
      send_pixel(pick_pixel(tex, base), p == start_at);
    end
  endtask

  // Stop sending and let every pending result and in-flight pixel drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sharp_q.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    case (idx)
      CFG_IMAGE_WIDTH:  reg_width  = IWIDTH_W'(value);
      CFG_IMAGE_HEIGHT: reg_height = IHEIGHT_W'(value);
      CFG_MASK_SIZE:    reg_mask   = MASK_W'(value);
      default: ;
    endcase
  endtask

  task automatic configure(input int width, input int height, input int mask);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, width);
    write_reg(CFG_IMAGE_HEIGHT, height);
    write_reg(CFG_MASK_SIZE, mask);
    cfg_we <= 1'b0;
    phases_run++;
  endtask

  // Power-on setting (640 x 480, 3 x 3): the first row gives no result; a
  // 1 x 1 window then carries on along the same row, one zero per pixel
  task automatic test_reset_defaults();
    send_run(16, 640, 0);
    wait_idle();
    write_reg(CFG_MASK_SIZE, 1);
    cfg_we <= 1'b0;
    send_run(32, 640, -1);
  endtask

  // Single 3 x 3 frames: saturate high, saturate low, land exactly on 255
  task automatic test_clamp_edges();
    logic [PIX_W-1:0] blk [3][9];
    int b;
    int p;
    blk[0] = '{0, 0, 0, 0, 255, 0, 0, 0, 0};
    blk[1] = '{255, 255, 255, 255, 0, 255, 255, 255, 255};
    blk[2] = '{8, 8, 8, 8, 40, 8, 8, 8, 9};
    configure(3, 3, 3);
    for (b = 0; b < 3; b++)
      for (p = 0; p < 9; p++) send_pixel(blk[b][p], p == 0);
  endtask

  // 1 x 1 window: a zero result for every pixel; mask register 0 acts as 1
  task automatic test_mask_one();
    configure(5, 2, 1);
    send_run(10, 5, 0);
    configure(4, 2, 0);
    send_run(8, 4, 0);
  endtask

  // Zero width and zero height saturate to one
  task automatic test_register_limits();
    configure(0, 3, 1);
    send_run(6, 1, 0);
    configure(4, 0, 1);
    send_run(8, 4, 0);
    configure(0, 0, 0);
    send_run(3, 1, 0);
  endtask

  // Frame wrap without frame_start, a frame cut short, a stray frame_start
  task automatic test_frame_wrap();
    configure(5, 4, 3);
    send_run(40, 5, 0);
    send_run(13, 5, 0);
    send_run(20, 5, 0);
    send_run(20, 5, 7);
  endtask

  // Largest window on a 16 x 7 frame, then a width register above the limit;
  // the frame leaves every line store and window entry in later use written
  task automatic test_largest_frame();
    no_idle = 1'b1;
    configure(16, 7, 7);
    send_run(16 * 7, 16, 0);
    configure(2047, 2, 1);
    send_run(20, 20, 0);
    no_idle = 1'b0;
  endtask

  // Height register above the limit saturates; a short run of 2 x 2 windows
  task automatic test_tallest_frame();
    configure(2, 8191, 2);
    send_run(40, 2, 0);
  endtask

  // Random small settings; mostly clean frames, some continuing from the
  // counters and some broken by a frame_start part-way through
  task automatic test_random_frames();
    int first, w, h, m, kind, area, count;
    first = pixels_sent;
    while (pixels_sent - first < RANDOM_PIXELS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
      m = $urandom_range(0, 7);
      configure(w, h, m);
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      area = w * h;
      repeat ($urandom_range(1, 3)) begin
        kind = $urandom_range(0, 19);
        if (kind < 14) begin
          send_run(area, w, 0);
        end else if (kind < 17) begin
          send_run(area, w, -1);
        end else begin
          count = $urandom_range(2, area + w);
          send_run(count, w, $urandom_range(1, count - 1));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int t;
    reset_predictor();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_clamp_edges();
    test_mask_one();
    test_register_limits();
    test_frame_wrap();
    test_largest_frame();
    test_tallest_frame();
    test_random_frames();

    // drain, bounded; anything still pending afterwards is a miss
    in_valid <= 1'b0;
    for (t = 0; t < 2000 && sharp_q.size() != 0; t++) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    if (sharp_q.size() != 0) begin
      $error("%0d expected results never arrived", sharp_q.size());
      error_count += sharp_q.size();
    end

    $display("Sent %0d pixels, checked %0d results over %0d register settings,",
             pixels_sent, results_checked, phases_run);
    $display("masks 0..7, widths 0..2047, heights 0..8191, with frame wrap and restarts.");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
